FILE: rtl/core/mfs_pkg.sv
// mfs_pkg: shared constants, payload structs and register codes for the
// streaming maxout block. No dependencies.
package mfs_pkg;

  localparam int unsigned VALUE_WIDTH = 16;
  localparam int unsigned MAX_FEATURE = 4096;
  localparam int unsigned SLOT_W      = $clog2(MAX_FEATURE);
  localparam int unsigned GROUP_W     = 8;
  localparam int unsigned FS_W        = 13;
  localparam int unsigned CMP_W       = (FS_W > SLOT_W + 1) ? FS_W : SLOT_W + 1;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] REG_GROUP_COUNT  = 2'd0;
  localparam logic [1:0] REG_CHANNEL_LAST = 2'd1;
  localparam logic [1:0] REG_FEATURE_SIZE = 2'd2;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] sample;
    logic                          tensor_end;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] group_max;
    logic                          final_result;
  } out_item_t;

  typedef struct packed {
    logic [GROUP_W-1:0] group_count;
    logic               channel_last;
    logic [FS_W-1:0]    feature_size;
  } cfg_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] sample;
    logic [SLOT_W-1:0]             slot;
    logic                          first;
    logic                          last;
    logic                          tensor_end;
  } req_t;

endpackage

FILE: rtl/core/mfs_front.sv
// mfs_front: group/feature counters; classifies each incoming sample into a request.
// Depends on mfs_pkg.
module mfs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mfs_pkg::cfg_t       cfg_i,
  input  logic                cfg_clear_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mfs_pkg::in_item_t   in_item_i,
  output logic                push_o,
  output mfs_pkg::req_t       req_o,
  input  logic                queue_full_i
);

  logic [mfs_pkg::GROUP_W-1:0] group_idx_q, group_idx_d;
  logic [mfs_pkg::SLOT_W-1:0]  feat_idx_q, feat_idx_d;
  logic [mfs_pkg::CMP_W-1:0]   fs_eff;
  logic [mfs_pkg::CMP_W-1:0]   feat_next;
  logic [mfs_pkg::GROUP_W:0]   group_next;
  logic                        last_member;
  logic                        feat_wrap;

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  always_comb begin
    if (cfg_i.feature_size == '0) begin
      fs_eff = mfs_pkg::CMP_W'(1);
    end else if (mfs_pkg::CMP_W'(cfg_i.feature_size) > mfs_pkg::CMP_W'(mfs_pkg::MAX_FEATURE)) begin
      fs_eff = mfs_pkg::CMP_W'(mfs_pkg::MAX_FEATURE);
    end else begin
      fs_eff = mfs_pkg::CMP_W'(cfg_i.feature_size);
    end
  end

  assign feat_next   = mfs_pkg::CMP_W'(feat_idx_q) + mfs_pkg::CMP_W'(1);
  assign feat_wrap   = feat_next >= fs_eff;
  assign group_next  = {1'b0, group_idx_q} + (mfs_pkg::GROUP_W+1)'(1);
  assign last_member = (cfg_i.group_count <= mfs_pkg::GROUP_W'(1)) ||
                       (group_next >= {1'b0, cfg_i.group_count});

  always_comb begin
    req_o.sample     = in_item_i.sample;
    req_o.slot       = cfg_i.channel_last ? '0 : feat_idx_q;
    req_o.first      = group_idx_q == '0;
    req_o.last       = last_member;
    req_o.tensor_end = in_item_i.tensor_end;
  end

  always_comb begin
    group_idx_d = group_idx_q;
    feat_idx_d  = feat_idx_q;
    if (cfg_clear_i) begin
      group_idx_d = '0;
      feat_idx_d  = '0;
    end else if (push_o) begin
      if (in_item_i.tensor_end) begin
        group_idx_d = '0;
        feat_idx_d  = '0;
      end else if (cfg_i.channel_last) begin
        feat_idx_d  = '0;
        group_idx_d = last_member ? '0 : group_next[mfs_pkg::GROUP_W-1:0];
      end else if (feat_wrap) begin
        feat_idx_d  = '0;
        group_idx_d = last_member ? '0 : group_next[mfs_pkg::GROUP_W-1:0];
      end else begin
        feat_idx_d = feat_next[mfs_pkg::SLOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_idx_q <= '0;
      feat_idx_q  <= '0;
    end else begin
      group_idx_q <= group_idx_d;
      feat_idx_q  <= feat_idx_d;
    end
  end

endmodule

FILE: rtl/core/mfs_queue.sv
// mfs_queue: short request FIFO between front and back.
// Depends on mfs_pkg.
module mfs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mfs_pkg::req_t push_req_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mfs_pkg::req_t head_o
);

  localparam int unsigned PTR_W = (mfs_pkg::QUEUE_DEPTH > 1) ? $clog2(mfs_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(mfs_pkg::QUEUE_DEPTH + 1);

  mfs_pkg::req_t    entry_q [mfs_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = count_q == CNT_W'(mfs_pkg::QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(mfs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(mfs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

FILE: rtl/core/mfs_ram.sv
// mfs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/core/mfs_back.sv
// mfs_back: partial-max store update, write-to-read bypass and result register.
// Depends on mfs_pkg and mfs_ram.
module mfs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  mfs_pkg::req_t      q_req_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mfs_pkg::out_item_t out_item_o
);

  logic                                   s1_valid_q;
  mfs_pkg::req_t                          s1_req_q;
  logic                                   fwd_hit_q;
  logic signed [mfs_pkg::VALUE_WIDTH-1:0] fwd_data_q;
  logic [mfs_pkg::VALUE_WIDTH-1:0]        ram_rdata;
  logic signed [mfs_pkg::VALUE_WIDTH-1:0] old_val;
  logic signed [mfs_pkg::VALUE_WIDTH-1:0] new_val;
  logic                                   out_valid_q;
  mfs_pkg::out_item_t                     out_item_q;
  logic                                   out_free;
  logic                                   s1_done;

  assign old_val  = fwd_hit_q ? fwd_data_q : $signed(ram_rdata);
  assign new_val  = (s1_req_q.first || (s1_req_q.sample > old_val)) ? s1_req_q.sample : old_val;
  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_done  = s1_valid_q && (!s1_req_q.last || out_free);
  assign pop_o    = q_valid_i && (!s1_valid_q || s1_done);

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  mfs_ram #(
    .WIDTH(mfs_pkg::VALUE_WIDTH),
    .DEPTH(mfs_pkg::MAX_FEATURE)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (s1_done),
    .waddr_i(s1_req_q.slot),
    .wdata_i(new_val),
    .re_i   (pop_o),
    .raddr_i(q_req_i.slot),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        s1_valid_q <= 1'b1;
      end else if (s1_done) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_done && s1_req_q.last) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // same-slot write landing on the read edge is bypassed
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_req_q   <= q_req_i;
      fwd_hit_q  <= s1_done && (s1_req_q.slot == q_req_i.slot);
      fwd_data_q <= new_val;
    end
    if (s1_done && s1_req_q.last) begin
      out_item_q.group_max    <= new_val;
      out_item_q.final_result <= s1_req_q.tensor_end;
    end
  end

endmodule

FILE: rtl/core/maxout_forward_stream.sv
// maxout_forward_stream: streaming maxout over channel groups, signed Q8.8.
// Depends on mfs_pkg, mfs_front, mfs_queue, mfs_back.
// Throughput: one sample per cycle while the queue is not full and the output is not stalled.
// Latency is set by the queue stage, the store's registered read port and the result register.
// Reset: group_count=2, channel_last=0, feature_size=1, counters cleared;
// partial-max store contents stay undefined (no clearing pass).
module maxout_forward_stream (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mfs_pkg::ADDR_W-1:0]    paddr,
  input  logic [mfs_pkg::DATA_W-1:0]    pwdata,
  output logic [mfs_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mfs_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mfs_pkg::out_item_t            out_item_o
);

  mfs_pkg::cfg_t cfg_q, cfg_d;
  logic          cfg_write;
  logic          cfg_clear;
  logic [1:0]    reg_idx;
  logic          push;
  logic          pop;
  logic          queue_full;
  logic          queue_valid;
  mfs_pkg::req_t front_req;
  mfs_pkg::req_t head_req;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = paddr[3:2];

  always_comb begin
    cfg_d     = cfg_q;
    cfg_clear = 1'b0;
    if (cfg_write) begin
      unique case (reg_idx)
        mfs_pkg::REG_GROUP_COUNT: begin
          cfg_d.group_count = pwdata[mfs_pkg::GROUP_W-1:0];
          cfg_clear         = 1'b1;
        end
        mfs_pkg::REG_CHANNEL_LAST: begin
          cfg_d.channel_last = pwdata[0];
          cfg_clear          = 1'b1;
        end
        mfs_pkg::REG_FEATURE_SIZE: begin
          cfg_d.feature_size = pwdata[mfs_pkg::FS_W-1:0];
          cfg_clear          = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mfs_pkg::REG_GROUP_COUNT:  prdata = mfs_pkg::DATA_W'(cfg_q.group_count);
      mfs_pkg::REG_CHANNEL_LAST: prdata = mfs_pkg::DATA_W'(cfg_q.channel_last);
      mfs_pkg::REG_FEATURE_SIZE: prdata = mfs_pkg::DATA_W'(cfg_q.feature_size);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.group_count  <= mfs_pkg::GROUP_W'(2);
      cfg_q.channel_last <= 1'b0;
      cfg_q.feature_size <= mfs_pkg::FS_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cfg_clear_i (cfg_clear),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .push_o      (push),
    .req_o       (front_req),
    .queue_full_i(queue_full)
  );

  mfs_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_req_i(front_req),
    .full_o    (queue_full),
    .pop_i     (pop),
    .valid_o   (queue_valid),
    .head_o    (head_req)
  );

  mfs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (queue_valid),
    .q_req_i    (head_req),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench for maxout_forward_stream (streaming maxout, signed Q8.8).
// Depends on mfs_pkg and the RTL only; checks every result against an in-bench group-max model.

module tb;
  import mfs_pkg::*;

  localparam logic [1:0]  REG_UNUSED  = 2'd3;
  localparam int unsigned RAND_ITEMS  = 750;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 10;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;

  // group-max model state
  cfg_t                         cfg_shadow;
  logic signed [VALUE_WIDTH-1:0] partial_max [MAX_FEATURE];
  logic [GROUP_W-1:0]           grp_idx;
  logic [FS_W-1:0]              feat_idx;
  out_item_t                    expected_max_q [$];

  int unsigned errors = 0;
  int unsigned n_req = 0;
  int unsigned n_res = 0;
  int unsigned n_cfg = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned pattern_len = 0;
  int unsigned pattern_kind = 0;

  maxout_forward_stream dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_max_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stall pattern, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (pattern_len == 0) begin
        pattern_len  <= $urandom_range(8, 64);
        pattern_kind <= $urandom_range(0, 3);
      end else begin
        pattern_len <= pattern_len - 1;
      end
      case (pattern_kind)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        2: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_stall <= ~out_stall;
        end
      endcase
    end
  end

  function automatic void clear_counters();
    grp_idx  = '0;
    feat_idx = '0;
  endfunction

  function automatic void maxout_predict(input in_item_t it, output bit emits,
                                         output out_item_t res);
    int unsigned       groups;
    int unsigned       fs;
    logic [SLOT_W-1:0] slot;
    bit                last_member;
    groups = (cfg_shadow.group_count < 1) ? 1 : cfg_shadow.group_count;
    fs = (cfg_shadow.feature_size < 1) ? 1 : cfg_shadow.feature_size;
    if (fs > MAX_FEATURE) fs = MAX_FEATURE;
    if (cfg_shadow.channel_last) feat_idx = '0;
    slot = feat_idx[SLOT_W-1:0];
    if (grp_idx == 0 || it.sample > partial_max[slot]) partial_max[slot] = it.sample;
    last_member = (grp_idx + 1 >= groups);
    emits = last_member;
    res.group_max    = partial_max[slot];
    res.final_result = it.tensor_end;
    if (it.tensor_end) begin
      clear_counters();
    end else if (cfg_shadow.channel_last) begin
      grp_idx = last_member ? '0 : grp_idx + 1'b1;
    end else begin
      feat_idx = feat_idx + 1'b1;
      if (feat_idx >= fs) begin
        feat_idx = '0;
        grp_idx  = last_member ? '0 : grp_idx + 1'b1;
      end
    end
  endfunction

  // inputs only change at the rising edge, so both handshakes are stable here
  always @(negedge clk) begin
    bit        emits;
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        n_req++;
        maxout_predict(in_item, emits, want);
        if (emits) expected_max_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        n_res++;
        if (expected_max_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result group_max=%0d final=%0b", $time,
                   out_item.group_max, out_item.final_result);
        end else begin
          want = expected_max_q.pop_front();
          if (out_item.group_max !== want.group_max) begin
            errors++;
            $display("%0t: group_max expected %0d actual %0d", $time,
                     want.group_max, out_item.group_max);
          end
          if (out_item.final_result !== want.final_result) begin
            errors++;
            $display("%0t: final_result expected %0b actual %0b", $time,
                     want.final_result, out_item.final_result);
          end
        end
      end
    end
  end

  function automatic logic signed [VALUE_WIDTH-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return VALUE_WIDTH'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] shadow_reg(input logic [1:0] idx);
    case (idx)
      REG_GROUP_COUNT:  return DATA_W'(cfg_shadow.group_count);
      REG_CHANNEL_LAST: return DATA_W'(cfg_shadow.channel_last);
      REG_FEATURE_SIZE: return DATA_W'(cfg_shadow.feature_size);
      default:          return '0;
    endcase
  endfunction

  task automatic send_sample(input logic signed [VALUE_WIDTH-1:0] value, input bit last_elem);
    int unsigned gap;
    bit          taken;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= '{sample: value, tensor_end: last_elem};
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_tensor(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_max_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic apb_access(input logic [1:0] idx, input bit wr, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    bit done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done  = pready;
      rdata = prdata;
      @(posedge clk);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [1:0] idx);
    logic [DATA_W-1:0] got;
    apb_access(idx, 1'b0, '0, got);
    if (got !== shadow_reg(idx)) begin
      errors++;
      $display("%0t: register %0d read expected %0d actual %0d", $time, idx,
               shadow_reg(idx), got);
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] unused;
    wait_idle();
    apb_access(idx, 1'b1, value, unused);
    n_cfg++;
    case (idx)
      REG_GROUP_COUNT:  cfg_shadow.group_count  = value[GROUP_W-1:0];
      REG_CHANNEL_LAST: cfg_shadow.channel_last = value[0];
      REG_FEATURE_SIZE: cfg_shadow.feature_size = value[FS_W-1:0];
      default:          return;
    endcase
    clear_counters();
    check_reg(idx);
  endtask

  task automatic test_reset_defaults();
    check_reg(REG_GROUP_COUNT);
    check_reg(REG_CHANNEL_LAST);
    check_reg(REG_FEATURE_SIZE);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'shffff, 1'b1);
  endtask

  task automatic test_small_groups();
    cfg_write(REG_GROUP_COUNT, 32'd0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    cfg_write(REG_GROUP_COUNT, 32'd1);
    send_sample(16'sh0001, 1'b1);
  endtask

  task automatic test_zero_feature_size();
    cfg_write(REG_GROUP_COUNT, 32'hffff_ff03);
    cfg_write(REG_FEATURE_SIZE, 32'd0);
    send_sample(16'sh0100, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh00ff, 1'b1);
  endtask

  task automatic test_truncated_tensor();
    cfg_write(REG_GROUP_COUNT, 32'd2);
    cfg_write(REG_FEATURE_SIZE, 32'd2);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'shffff, 1'b0);
    send_sample(16'sh0002, 1'b0);
    send_sample(16'shfffe, 1'b1);
  endtask

  task automatic test_write_clears_counters();
    cfg_write(REG_GROUP_COUNT, 32'd3);
    cfg_write(REG_FEATURE_SIZE, 32'd1);
    send_sample(16'sh7fff, 1'b0);
    cfg_write(REG_FEATURE_SIZE, 32'd1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0010, 1'b0);
    send_sample(16'shffff, 1'b1);
    // a write past the register list must leave the counters alone
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh0000, 1'b0);
    cfg_write(REG_UNUSED, 32'hffff_ffff);
    send_sample(16'sh0001, 1'b1);
  endtask

  task automatic test_channel_last();
    cfg_write(REG_CHANNEL_LAST, 32'd1);
    cfg_write(REG_FEATURE_SIZE, 32'd7);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8001, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh1234, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh0000, 1'b1);
  endtask

  task automatic test_wide_groups();
    cfg_write(REG_GROUP_COUNT, 32'd255);
    cfg_write(REG_CHANNEL_LAST, 32'd1);
    send_tensor(510);
    cfg_write(REG_CHANNEL_LAST, 32'd0);
    cfg_write(REG_FEATURE_SIZE, 32'd2);
    send_tensor(510);
  endtask

  task automatic test_large_feature_size();
    cfg_write(REG_GROUP_COUNT, 32'd2);
    cfg_write(REG_FEATURE_SIZE, 32'd4096);
    send_tensor(MAX_FEATURE + 3);
    // above the store depth the size saturates
    cfg_write(REG_FEATURE_SIZE, 32'd8191);
    send_tensor(MAX_FEATURE + 3);
  endtask

  task automatic test_backpressure();
    cfg_write(REG_GROUP_COUNT, 32'd0);
    cfg_write(REG_FEATURE_SIZE, 32'd1);
    hold_seq <= hold_seq + 1;
    send_tensor(80);
  endtask

  task automatic test_random_tensors();
    int unsigned sent;
    int unsigned gc;
    int unsigned fs;
    int unsigned unit;
    int unsigned len;
    bit          cl;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       gc = $urandom_range(0, 1);
        1:       gc = $urandom_range(200, 255);
        2, 3, 4: gc = $urandom_range(5, 16);
        default: gc = $urandom_range(2, 4);
      endcase
      cl = 1'($urandom_range(0, 1));
      fs = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, (gc > 16) ? 1 : 8);
      cfg_write(REG_GROUP_COUNT, gc);
      cfg_write(REG_CHANNEL_LAST, DATA_W'(cl));
      cfg_write(REG_FEATURE_SIZE, fs);
      gc   = (gc < 1) ? 1 : gc;
      fs   = (fs < 1) ? 1 : fs;
      unit = cl ? gc : gc * fs;
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 6) == 0) len = $urandom_range(1, 2 * unit);
        else len = unit * $urandom_range(1, (gc > 16) ? 1 : 4);
        send_tensor(len);
        sent += len;
      end
    end
  endtask

  initial begin
    cfg_shadow = '{group_count: 8'd2, channel_last: 1'b0, feature_size: 13'd1};
    clear_counters();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_small_groups();
    test_zero_feature_size();
    test_truncated_tensor();
    test_write_clears_counters();
    test_channel_last();
    test_wide_groups();
    test_large_feature_size();
    test_backpressure();
    test_random_tensors();
    wait_idle();
    $display("Streamed %0d requests, checked %0d group maxima, %0d register writes.",
             n_req, n_res, n_cfg);
    $display("Both layouts, group and feature-size extremes, truncated tensors, hold-off.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/mfs_pkg.sv
rtl/core/mfs_front.sv
rtl/core/mfs_queue.sv
rtl/core/mfs_ram.sv
rtl/core/mfs_back.sv
rtl/core/maxout_forward_stream.sv
tb/sv/tb.sv
